// ----- src/aob_pkg.sv -----
// aob_pkg: shared types and constants for the alpha over blend core
// no dependencies
`timescale 1ns / 1ps

package aob_pkg;
    localparam int unsigned NUM_W = 24;   // width of weighted color sums
    localparam int unsigned TOT_W = 16;   // width of the total weight
    localparam logic [7:0] FULL_ALPHA = 8'd255;

    // one transaction moving through the divider stages
    typedef struct packed {
        logic [NUM_W-1:0] rem_r;
        logic [NUM_W-1:0] rem_g;
        logic [NUM_W-1:0] rem_b;
        logic [7:0]       q_r;
        logic [7:0]       q_g;
        logic [7:0]       q_b;
        logic [TOT_W-1:0] total;
        logic [7:0]       alpha;
    } t_div;
endpackage

// ----- src/aob_weight.sv -----
// aob_weight: four register stages capturing pixels and forming weights, products, sums and alpha
// depends on aob_pkg
`timescale 1ns / 1ps

module aob_weight (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_dst_alpha,
    input  logic [7:0]    i_dst_red,
    input  logic [7:0]    i_dst_green,
    input  logic [7:0]    i_dst_blue,
    input  logic [7:0]    i_src_alpha,
    input  logic [7:0]    i_src_red,
    input  logic [7:0]    i_src_green,
    input  logic [7:0]    i_src_blue,
    output logic          o_valid,
    input  logic          i_ready,
    output aob_pkg::t_div o_data
);
    import aob_pkg::*;

    logic r_va, r_vb, r_vc, r_vd;
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;

    // stage a: captured pixels
    logic [7:0] r_a_da, r_a_sa;
    logic [7:0] r_a_sr, r_a_sg, r_a_sb, r_a_dr, r_a_dg, r_a_db;
    // stage b: weights
    logic [TOT_W-1:0] r_b_ws, r_b_wd;
    logic [7:0] r_b_sr, r_b_sg, r_b_sb, r_b_dr, r_b_dg, r_b_db;
    // stage c: products and total
    logic [NUM_W-1:0] r_c_psr, r_c_psg, r_c_psb, r_c_pdr, r_c_pdg, r_c_pdb;
    logic [TOT_W-1:0] r_c_tot;
    // stage d: output
    t_div r_d;

    logic [TOT_W:0]   n_tot;
    logic [NUM_W-1:0] n_alpha;

    assign w_rdy_d = !r_vd || i_ready;
    assign w_rdy_c = !r_vc || w_rdy_d;
    assign w_rdy_b = !r_vb || w_rdy_c;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;
    assign o_valid = r_vd;
    assign o_data  = r_d;

    assign n_tot   = {1'b0, r_b_ws} + {1'b0, r_b_wd};
    // floor(x/255) as ((x+1)*257)>>16, exact for x up to 65279 in the 24-bit product
    assign n_alpha = (NUM_W'(r_c_tot) + NUM_W'(1)) * NUM_W'(257);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (w_rdy_a) r_va <= i_valid;
            if (w_rdy_b) r_vb <= r_va;
            if (w_rdy_c) r_vc <= r_vb;
            if (w_rdy_d) r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_da <= i_dst_alpha;
            r_a_sa <= i_src_alpha;
            r_a_sr <= i_src_red;
            r_a_sg <= i_src_green;
            r_a_sb <= i_src_blue;
            r_a_dr <= i_dst_red;
            r_a_dg <= i_dst_green;
            r_a_db <= i_dst_blue;
        end
        if (w_rdy_b) begin
            r_b_ws <= TOT_W'(r_a_sa) * TOT_W'(FULL_ALPHA);
            r_b_wd <= TOT_W'(r_a_da) * TOT_W'(FULL_ALPHA - r_a_sa);
            r_b_sr <= r_a_sr;
            r_b_sg <= r_a_sg;
            r_b_sb <= r_a_sb;
            r_b_dr <= r_a_dr;
            r_b_dg <= r_a_dg;
            r_b_db <= r_a_db;
        end
        if (w_rdy_c) begin
            r_c_psr <= NUM_W'(r_b_sr) * NUM_W'(r_b_ws);
            r_c_psg <= NUM_W'(r_b_sg) * NUM_W'(r_b_ws);
            r_c_psb <= NUM_W'(r_b_sb) * NUM_W'(r_b_ws);
            r_c_pdr <= NUM_W'(r_b_dr) * NUM_W'(r_b_wd);
            r_c_pdg <= NUM_W'(r_b_dg) * NUM_W'(r_b_wd);
            r_c_pdb <= NUM_W'(r_b_db) * NUM_W'(r_b_wd);
            r_c_tot <= n_tot[TOT_W-1:0];
        end
        if (w_rdy_d) begin
            r_d.rem_r <= r_c_psr + r_c_pdr;
            r_d.rem_g <= r_c_psg + r_c_pdg;
            r_d.rem_b <= r_c_psb + r_c_pdb;
            r_d.q_r   <= '0;
            r_d.q_g   <= '0;
            r_d.q_b   <= '0;
            // zero total: sums are zero too, dividing by one gives zero
            r_d.total <= (r_c_tot == '0) ? TOT_W'(1) : r_c_tot;
            r_d.alpha <= n_alpha[23:16];
        end
    end
endmodule

// ----- src/aob_div_step.sv -----
// aob_div_step: one restoring division step for the three color channels
// depends on aob_pkg
`timescale 1ns / 1ps

module aob_div_step #(
    parameter int BIT = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  aob_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output aob_pkg::t_div o_data
);
    import aob_pkg::*;

    logic             r_v;
    t_div             r_d;
    t_div             n_d;
    logic [NUM_W-1:0] w_div;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_data  = r_d;
    assign w_div   = NUM_W'(i_data.total) << BIT;

    always_comb begin
        n_d = i_data;
        if (i_data.rem_r >= w_div) begin
            n_d.rem_r    = i_data.rem_r - w_div;
            n_d.q_r[BIT] = 1'b1;
        end
        if (i_data.rem_g >= w_div) begin
            n_d.rem_g    = i_data.rem_g - w_div;
            n_d.q_g[BIT] = 1'b1;
        end
        if (i_data.rem_b >= w_div) begin
            n_d.rem_b    = i_data.rem_b - w_div;
            n_d.q_b[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) r_d <= n_d;
    end
endmodule

// ----- src/alpha_over_blend_core.sv -----
// alpha_over_blend_core: source over destination compositing, one pixel per cycle while the output is not stalled
// depends on aob_pkg, aob_weight, aob_div_step
`timescale 1ns / 1ps

// Usage
// Input channel: i_valid / o_ready with destination and source pixels
// (alpha, red, green, blue bytes). Output channel: o_valid / i_ready with
// the composite alpha and colors.
// One input transaction gives one output transaction, in order.
// Four stages form the weights, products, weighted sums and alpha, then
// eight stages each resolve one quotient bit of the three color
// divisions.
// Throughput is one transaction per cycle while the receiver takes results.
// Each stage holds its own valid bit and advances when the next stage is
// empty or moving, so bubbles are squeezed out; a stall at the output
// backs up stage by stage and nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits; the pipeline comes up
// empty and ready.
module alpha_over_blend_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_dst_alpha,
    input  logic [7:0] i_dst_red,
    input  logic [7:0] i_dst_green,
    input  logic [7:0] i_dst_blue,
    input  logic [7:0] i_src_alpha,
    input  logic [7:0] i_src_red,
    input  logic [7:0] i_src_green,
    input  logic [7:0] i_src_blue,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_alpha,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue
);
    import aob_pkg::*;

    t_div s_d [0:8];
    logic s_v [0:8];
    logic s_r [0:8];

    aob_weight u_weight (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_dst_alpha (i_dst_alpha),
        .i_dst_red   (i_dst_red),
        .i_dst_green (i_dst_green),
        .i_dst_blue  (i_dst_blue),
        .i_src_alpha (i_src_alpha),
        .i_src_red   (i_src_red),
        .i_src_green (i_src_green),
        .i_src_blue  (i_src_blue),
        .o_valid     (s_v[0]),
        .i_ready     (s_r[0]),
        .o_data      (s_d[0])
    );

    for (genvar k = 0; k < 8; k++) begin : g_div
        aob_div_step #(.BIT(7 - k)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_v[k]),
            .o_ready (s_r[k]),
            .i_data  (s_d[k]),
            .o_valid (s_v[k+1]),
            .i_ready (s_r[k+1]),
            .o_data  (s_d[k+1])
        );
    end

    assign s_r[8]      = i_ready;
    assign o_valid     = s_v[8];
    assign o_out_alpha = s_d[8].alpha;
    assign o_out_red   = s_d[8].q_r;
    assign o_out_green = s_d[8].q_g;
    assign o_out_blue  = s_d[8].q_b;
endmodule

// ----- src/aob_checker.sv -----
// aob_checker: port-level checks for alpha_over_blend_core, bound to the top
// depends on alpha_over_blend_core ports only
`timescale 1ns / 1ps

module aob_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_alpha,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_blue
);
    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output valid dropped during stall");

    // a stalled result keeps its value
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out_alpha) && $stable(o_out_red)
            && $stable(o_out_green) && $stable(o_out_blue))
        else $error("output payload changed during stall");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // zero coverage only comes from zero total weight, so colors are zero
    a_clear_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_alpha == 8'd0 |->
            o_out_red == 8'd0 && o_out_green == 8'd0 && o_out_blue == 8'd0)
        else $error("nonzero color with zero alpha");
endmodule

bind alpha_over_blend_core aob_checker u_aob_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_alpha (o_out_alpha),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue)
);
